// File: rtl/core/bnb_pkg.sv
package bnb_pkg;

   localparam int NUM_ATTRS  = 4;
   localparam int COUNT_BITS = 10;

   localparam int FEAT_W     = 4;
   localparam int SCORE_W    = 17;
   localparam int FRAC_BITS  = 16;

   // Product of the running score and a count, and the widest divisor (sum of both totals).
   localparam int PROD_W     = SCORE_W + COUNT_BITS;
   localparam int DIVR_W     = COUNT_BITS + 1;
   localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

   localparam int ATTR_IDX_W = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
   localparam int ATTR_CNT_W = $clog2(NUM_ATTRS + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [SCORE_W-1:0]    ONE_FIXED = SCORE_W'(1) << FRAC_BITS;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_TRAIN = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_TRAIN,
      CMD_QUERY,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [NUM_ATTRS-1:0] feats;
      logic                 cls;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/core/bnb_front.sv
module bnb_front (
   input  logic                           req_valid,
   input  logic [1:0]                     req_opcode,
   input  logic [bnb_pkg::FEAT_W-1:0]     req_feature_bits,
   input  logic                           req_class_bit,
   input  logic                           q_full,
   output logic                           req_ready,
   output logic                           q_push,
   output bnb_pkg::cmd_type               q_cmd
);

   logic [bnb_pkg::NUM_ATTRS-1:0] feats_ext;

   // Attributes beyond the width of the input field read as no.
   always_comb begin
      for (int j = 0; j < bnb_pkg::NUM_ATTRS; j++) begin
         if (j < bnb_pkg::FEAT_W) begin
            feats_ext[j] = req_feature_bits[j];
         end else begin
            feats_ext[j] = 1'b0;
         end
      end
   end

   always_comb begin
      q_cmd.feats = feats_ext;
      q_cmd.cls   = req_class_bit;
      case (req_opcode)
         bnb_pkg::OP_CLEAR: q_cmd.kind = bnb_pkg::CMD_CLEAR;
         bnb_pkg::OP_TRAIN: q_cmd.kind = bnb_pkg::CMD_TRAIN;
         bnb_pkg::OP_QUERY: q_cmd.kind = bnb_pkg::CMD_QUERY;
         default:           q_cmd.kind = bnb_pkg::CMD_NOP;
      endcase
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// File: rtl/core/bnb_fifo.sv
module bnb_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bnb_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             q_valid,
   output bnb_pkg::cmd_type q_cmd
);

   bnb_pkg::cmd_type               mem_ff [bnb_pkg::QUEUE_DEPTH];
   logic [bnb_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bnb_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bnb_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;

   function automatic logic [bnb_pkg::QPTR_W-1:0] ptr_next(input logic [bnb_pkg::QPTR_W-1:0] p);
      logic [bnb_pkg::QPTR_W-1:0] r;
      if (p == bnb_pkg::QPTR_W'(bnb_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign full    = (cnt_ff == bnb_pkg::QCNT_W'(bnb_pkg::QUEUE_DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/bnb_div.sv
module bnb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bnb_pkg::div_req_type div_req,
   output bnb_pkg::div_rsp_type div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bnb_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [bnb_pkg::DIVR_W-1:0]    rem_ff, rem_in;
   logic [bnb_pkg::DIVR_W-1:0]    divisor_ff, divisor_in;
   logic [bnb_pkg::PROD_W-1:0]    quo_ff, quo_in;
   logic [bnb_pkg::DIVR_W:0]      rem_sh;
   logic [bnb_pkg::DIVR_W:0]      rem_sub;
   logic                          fits;

   // Restoring division, one quotient bit per cycle; the dividend shifts out
   // of the top of quo_ff while quotient bits enter at the bottom.
   always_comb begin
      rem_sh     = {rem_ff, quo_ff[bnb_pkg::PROD_W-1]};
      rem_sub    = rem_sh - {1'b0, divisor_ff};
      fits       = (rem_sh >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = bnb_pkg::DIV_CNT_W'(bnb_pkg::PROD_W);
         rem_in     = '0;
         divisor_in = div_req.divisor;
         quo_in     = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[bnb_pkg::DIVR_W-1:0] : rem_sh[bnb_pkg::DIVR_W-1:0];
         quo_in = {quo_ff[bnb_pkg::PROD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == bnb_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: rtl/core/bnb_back.sv
module bnb_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  bnb_pkg::cmd_type               q_cmd,
   output logic                           q_pop,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bnb_pkg::SCORE_W-1:0]    rsp_score,
   output logic                           rsp_undefined,
   output logic                           rsp_saturated
);

   bnb_pkg::back_state_type state_ff, state_in;

   logic [bnb_pkg::COUNT_BITS-1:0] yes_ff [2][bnb_pkg::NUM_ATTRS];
   logic [bnb_pkg::COUNT_BITS-1:0] yes_in [2][bnb_pkg::NUM_ATTRS];
   logic [bnb_pkg::COUNT_BITS-1:0] tot_ff [2];
   logic [bnb_pkg::COUNT_BITS-1:0] tot_in [2];

   logic                            cls_ff, cls_in;
   logic [bnb_pkg::NUM_ATTRS-1:0]   feat_ff, feat_in;
   logic [bnb_pkg::SCORE_W-1:0]     p_ff, p_in;
   logic [bnb_pkg::ATTR_CNT_W-1:0]  step_ff, step_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bnb_pkg::SCORE_W-1:0]     score_ff, score_in;
   logic                            undef_ff, undef_in;
   logic                            sat_ff, sat_in;

   logic                            slot_free;
   logic [bnb_pkg::ATTR_IDX_W-1:0]  idx;
   logic [bnb_pkg::COUNT_BITS-1:0]  total;
   logic [bnb_pkg::COUNT_BITS-1:0]  yes_sel;
   logic [bnb_pkg::COUNT_BITS-1:0]  match;
   logic [bnb_pkg::DIVR_W-1:0]      all_sum;

   bnb_pkg::div_req_type div_req;
   bnb_pkg::div_rsp_type div_rsp;

   bnb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign idx       = step_ff[bnb_pkg::ATTR_IDX_W-1:0];
   assign total     = tot_ff[cls_ff];
   assign yes_sel   = yes_ff[cls_ff][idx];
   assign match     = feat_ff[idx] ? yes_sel : (total - yes_sel);
   assign all_sum   = {1'b0, tot_ff[0]} + {1'b0, tot_ff[1]};

   always_comb begin
      state_in     = state_ff;
      yes_in       = yes_ff;
      tot_in       = tot_ff;
      cls_in       = cls_ff;
      feat_in      = feat_ff;
      p_in         = p_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      score_in     = score_ff;
      undef_in     = undef_ff;
      sat_in       = sat_ff;
      q_pop        = 1'b0;
      div_req      = '0;

      case (state_ff)
         bnb_pkg::ST_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop    = 1'b1;
               score_in = '0;
               undef_in = 1'b0;
               sat_in   = 1'b0;
               case (q_cmd.kind)
                  bnb_pkg::CMD_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     for (int c = 0; c < 2; c++) begin
                        tot_in[c] = '0;
                        for (int j = 0; j < bnb_pkg::NUM_ATTRS; j++) begin
                           yes_in[c][j] = '0;
                        end
                     end
                  end
                  bnb_pkg::CMD_TRAIN: begin
                     rsp_valid_in = 1'b1;
                     // A yes count never exceeds its class total, so only the total can fill.
                     if (tot_ff[q_cmd.cls] == bnb_pkg::COUNT_MAX) begin
                        sat_in = 1'b1;
                     end else begin
                        tot_in[q_cmd.cls] = tot_ff[q_cmd.cls] + 1'b1;
                        for (int j = 0; j < bnb_pkg::NUM_ATTRS; j++) begin
                           yes_in[q_cmd.cls][j] = yes_ff[q_cmd.cls][j]
                                                + bnb_pkg::COUNT_BITS'(q_cmd.feats[j]);
                        end
                     end
                  end
                  bnb_pkg::CMD_QUERY: begin
                     if (tot_ff[q_cmd.cls] == '0) begin
                        rsp_valid_in = 1'b1;
                        undef_in     = 1'b1;
                     end else begin
                        cls_in   = q_cmd.cls;
                        feat_in  = q_cmd.feats;
                        p_in     = bnb_pkg::ONE_FIXED;
                        step_in  = '0;
                        state_in = bnb_pkg::ST_MUL;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         bnb_pkg::ST_MUL: begin
            div_req.start = 1'b1;
            if (step_ff == bnb_pkg::ATTR_CNT_W'(bnb_pkg::NUM_ATTRS)) begin
               // Prior: multiply by the class total and divide by the sum of both class totals.
               div_req.dividend = bnb_pkg::PROD_W'(p_ff) * bnb_pkg::PROD_W'(total);
               div_req.divisor  = all_sum;
            end else begin
               div_req.dividend = bnb_pkg::PROD_W'(p_ff) * bnb_pkg::PROD_W'(match);
               div_req.divisor  = bnb_pkg::DIVR_W'(total);
            end
            state_in = bnb_pkg::ST_DIV;
         end
         bnb_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               p_in = div_rsp.quotient[bnb_pkg::SCORE_W-1:0];
               if (step_ff == bnb_pkg::ATTR_CNT_W'(bnb_pkg::NUM_ATTRS)) begin
                  state_in = bnb_pkg::ST_OUT;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = bnb_pkg::ST_MUL;
               end
            end
         end
         bnb_pkg::ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               score_in     = p_ff;
               undef_in     = 1'b0;
               sat_in       = 1'b0;
               state_in     = bnb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bnb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bnb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 2; c++) begin
            tot_ff[c] <= '0;
            for (int j = 0; j < bnb_pkg::NUM_ATTRS; j++) begin
               yes_ff[c][j] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tot_ff       <= tot_in;
         yes_ff       <= yes_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff   <= cls_in;
      feat_ff  <= feat_in;
      p_ff     <= p_in;
      step_ff  <= step_in;
      score_ff <= score_in;
      undef_ff <= undef_in;
      sat_ff   <= sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_score     = score_ff;
   assign rsp_undefined = undef_ff;
   assign rsp_saturated = sat_ff;

endmodule

// File: rtl/core/binary_naive_bayes_classifier_core.sv
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_opcode, req_feature_bits, req_class_bit
// rsp       out        rsp_valid, rsp_ready, rsp_score, rsp_undefined, rsp_saturated
//
// Clear, train and no-operation transactions are answered directly from the idle state of the
// back end. A query runs five chained divisions through one shared restoring divider, one
// quotient bit per cycle.
// Reset is synchronous and zeroes all counts at once; no clearing pass is needed.
// A two-entry queue accepts requests while a query runs or a result waits, until it is full.
module binary_naive_bayes_classifier_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [bnb_pkg::FEAT_W-1:0]  req_feature_bits,
   input  logic                        req_class_bit,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bnb_pkg::SCORE_W-1:0] rsp_score,
   output logic                        rsp_undefined,
   output logic                        rsp_saturated
);

   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_valid;
   bnb_pkg::cmd_type push_cmd;
   bnb_pkg::cmd_type head_cmd;

   bnb_front u_front (
      .req_valid        (req_valid),
      .req_opcode       (req_opcode),
      .req_feature_bits (req_feature_bits),
      .req_class_bit    (req_class_bit),
      .q_full           (q_full),
      .req_ready        (req_ready),
      .q_push           (q_push),
      .q_cmd            (push_cmd)
   );

   bnb_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .q_valid  (q_valid),
      .q_cmd    (head_cmd)
   );

   bnb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (head_cmd),
      .q_pop         (q_pop),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_score     (rsp_score),
      .rsp_undefined (rsp_undefined),
      .rsp_saturated (rsp_saturated)
   );

   // A flagged transaction never carries a score.
   a_flag_zero_score : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_undefined || rsp_saturated) |-> rsp_score == '0)
      else $error("flagged result with non-zero score");

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_undefined && rsp_saturated))
      else $error("undefined and saturated both set");

   a_score_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_score <= bnb_pkg::ONE_FIXED)
      else $error("score above one");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule

// File: sim/tb.sv
module tb;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 450;
   localparam int PRINT_CAP    = 100;

   typedef struct packed {
      logic [bnb_pkg::SCORE_W-1:0] score;
      logic                        undefined;
      logic                        saturated;
   } verdict_type;

   // Keeps its own copy of the class and attribute counts, works out the verdict of every
   // accepted request, and checks each response against the oldest verdict still owed.
   class bayes_tracker;
      logic [bnb_pkg::COUNT_BITS-1:0] class_count [2];
      logic [bnb_pkg::COUNT_BITS-1:0] yes_count [2][bnb_pkg::NUM_ATTRS];
      verdict_type                    owed[$];
      int                             mismatches;
      int                             results_seen;
      int                             trains;
      int                             dropped;
      int                             queries;
      int                             empty_queries;
      int                             others;

      function new();
         wipe();
      endfunction

      function void wipe();
         foreach (class_count[c]) class_count[c] = '0;
         foreach (yes_count[c, j]) yes_count[c][j] = '0;
      endfunction

      // Running product of matching count over class count, truncated after each factor,
      // then scaled by the prior of the queried class.
      function logic [bnb_pkg::SCORE_W-1:0] posterior(logic [bnb_pkg::FEAT_W-1:0] feats,
                                                      logic cls);
         logic [bnb_pkg::PROD_W-1:0]     prod;
         logic [bnb_pkg::SCORE_W-1:0]    p;
         logic [bnb_pkg::COUNT_BITS-1:0] total;
         logic [bnb_pkg::COUNT_BITS-1:0] hits;
         logic [bnb_pkg::DIVR_W-1:0]     grand;
         total = class_count[cls];
         grand = bnb_pkg::DIVR_W'(class_count[0]) + bnb_pkg::DIVR_W'(class_count[1]);
         p = bnb_pkg::ONE_FIXED;
         for (int j = 0; j < bnb_pkg::NUM_ATTRS; j++) begin
            hits = feats[j] ? yes_count[cls][j] : total - yes_count[cls][j];
            prod = bnb_pkg::PROD_W'(p) * bnb_pkg::PROD_W'(hits);
            p = bnb_pkg::SCORE_W'(prod / bnb_pkg::PROD_W'(total));
         end
         prod = bnb_pkg::PROD_W'(p) * bnb_pkg::PROD_W'(total);
         return bnb_pkg::SCORE_W'(prod / bnb_pkg::PROD_W'(grand));
      endfunction

      function void note_request(bnb_pkg::cmd_kind_type op, logic [bnb_pkg::FEAT_W-1:0] feats,
                                 logic cls);
         verdict_type v;
         v = '0;
         case (op)
            bnb_pkg::CMD_CLEAR: begin
               wipe();
               others++;
            end
            bnb_pkg::CMD_TRAIN: begin
               trains++;
               if (class_count[cls] == bnb_pkg::COUNT_MAX) begin
                  v.saturated = 1'b1;
                  dropped++;
               end else begin
                  class_count[cls]++;
                  for (int j = 0; j < bnb_pkg::NUM_ATTRS; j++)
                     if (feats[j]) yes_count[cls][j]++;
               end
            end
            bnb_pkg::CMD_QUERY: begin
               queries++;
               if (class_count[cls] == '0) begin
                  v.undefined = 1'b1;
                  empty_queries++;
               end else begin
                  v.score = posterior(feats, cls);
               end
            end
            default: others++;
         endcase
         owed.push_back(v);
      endfunction

      // Only the first hundred mismatches are printed, to keep the log readable; all are counted.
      task complain(string what);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("mismatch: %s", what);
      endtask

      task check_response(logic [bnb_pkg::SCORE_W-1:0] score, logic undefined, logic saturated);
         verdict_type want;
         results_seen++;
         if (owed.size() == 0) begin
            complain($sformatf("result %0d arrived with nothing outstanding (score %0d)",
                               results_seen, score));
            return;
         end
         want = owed.pop_front();
         if (score !== want.score)
            complain($sformatf("result %0d: score %0d, expected %0d",
                               results_seen, score, want.score));
         if (undefined !== want.undefined)
            complain($sformatf("result %0d: undefined %b, expected %b",
                               results_seen, undefined, want.undefined));
         if (saturated !== want.saturated)
            complain($sformatf("result %0d: saturated %b, expected %b",
                               results_seen, saturated, want.saturated));
      endtask

      function int outstanding();
         return owed.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_opcode = bnb_pkg::OP_NOP;
   logic [bnb_pkg::FEAT_W-1:0]  req_feature_bits = '0;
   logic                        req_class_bit = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [bnb_pkg::SCORE_W-1:0] rsp_score;
   logic                        rsp_undefined;
   logic                        rsp_saturated;

   bayes_tracker tracker = new();
   bit           no_idle = 1'b0;
   int           cycle_count = 0;

   binary_naive_bayes_classifier_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_feature_bits (req_feature_bits),
      .req_class_bit    (req_class_bit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_score        (rsp_score),
      .rsp_undefined    (rsp_undefined),
      .rsp_saturated    (rsp_saturated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("FAIL binary_naive_bayes_classifier_core");
         $finish;
      end
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic issue_command(bnb_pkg::cmd_kind_type op, logic [bnb_pkg::FEAT_W-1:0] feats,
                                logic cls);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_feature_bits <= feats;
      req_class_bit    <= cls;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(op, feats, cls);
   endtask

   task automatic wait_for_answers();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   initial begin : answer_side
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait();
         @(negedge clock);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         tracker.check_response(rsp_score, rsp_undefined, rsp_saturated);
      end
   end

   initial begin : command_side
      int                         k;
      int                         r;
      int                         sent;
      int                         span;
      int                         bias;
      logic [bnb_pkg::FEAT_W-1:0] f;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Queries on empty classes, then a small hand-made training set with extreme patterns.
      issue_command(bnb_pkg::CMD_QUERY, 4'h0, 1'b0);
      issue_command(bnb_pkg::CMD_QUERY, 4'hF, 1'b1);
      issue_command(bnb_pkg::CMD_NOP,   4'hF, 1'b1);
      issue_command(bnb_pkg::CMD_TRAIN, 4'hF, 1'b1);
      issue_command(bnb_pkg::CMD_TRAIN, 4'h0, 1'b1);
      issue_command(bnb_pkg::CMD_TRAIN, 4'h5, 1'b0);
      issue_command(bnb_pkg::CMD_TRAIN, 4'hA, 1'b0);
      issue_command(bnb_pkg::CMD_TRAIN, 4'h3, 1'b1);
      issue_command(bnb_pkg::CMD_QUERY, 4'hF, 1'b1);
      issue_command(bnb_pkg::CMD_QUERY, 4'h0, 1'b1);
      issue_command(bnb_pkg::CMD_QUERY, 4'h5, 1'b0);
      issue_command(bnb_pkg::CMD_QUERY, 4'hF, 1'b0);
      issue_command(bnb_pkg::CMD_QUERY, 4'h0, 1'b0);
      issue_command(bnb_pkg::CMD_NOP,   4'h0, 1'b0);
      issue_command(bnb_pkg::CMD_TRAIN, 4'hF, 1'b0);
      issue_command(bnb_pkg::CMD_QUERY, 4'hA, 1'b1);
      issue_command(bnb_pkg::CMD_CLEAR, 4'hF, 1'b1);
      issue_command(bnb_pkg::CMD_QUERY, 4'hF, 1'b0);
      issue_command(bnb_pkg::CMD_QUERY, 4'hF, 1'b1);
      issue_command(bnb_pkg::CMD_TRAIN, 4'hF, 1'b1);
      issue_command(bnb_pkg::CMD_QUERY, 4'hF, 1'b1);
      issue_command(bnb_pkg::CMD_QUERY, 4'h0, 1'b1);
      wait_for_answers();

      // Fill both class totals to the top so that further training is dropped.
      no_idle = 1'b1;
      issue_command(bnb_pkg::CMD_CLEAR, 4'h0, 1'b0);
      for (k = 0; k < int'(bnb_pkg::COUNT_MAX); k++) begin
         issue_command(bnb_pkg::CMD_TRAIN, bnb_pkg::FEAT_W'($urandom), 1'b0);
         if (k % 256 == 255)
            issue_command(bnb_pkg::CMD_QUERY, bnb_pkg::FEAT_W'($urandom), 1'b0);
      end
      issue_command(bnb_pkg::CMD_TRAIN, 4'hF, 1'b0);
      issue_command(bnb_pkg::CMD_TRAIN, 4'h0, 1'b0);
      issue_command(bnb_pkg::CMD_QUERY, 4'h9, 1'b1);
      for (k = 0; k < int'(bnb_pkg::COUNT_MAX); k++)
         issue_command(bnb_pkg::CMD_TRAIN, 4'hF, 1'b1);
      issue_command(bnb_pkg::CMD_TRAIN, 4'h6, 1'b1);
      no_idle = 1'b0;
      issue_command(bnb_pkg::CMD_QUERY, 4'hF, 1'b1);
      issue_command(bnb_pkg::CMD_QUERY, 4'h7, 1'b1);
      for (k = 0; k < 6; k++)
         issue_command(bnb_pkg::CMD_QUERY, bnb_pkg::FEAT_W'($urandom), 1'($urandom));
      wait_for_answers();

      // Random episodes: mostly training and querying, with the odd clear and no-operation.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         span = $urandom_range(8, 40);
         bias = $urandom_range(0, 2);
         if ($urandom_range(0, 1) == 1) begin
            issue_command(bnb_pkg::CMD_CLEAR, bnb_pkg::FEAT_W'($urandom), 1'($urandom));
            sent++;
         end
         for (k = 0; k < span; k++) begin
            r = $urandom_range(0, 99);
            f = bnb_pkg::FEAT_W'($urandom);
            if (r < 3) begin
               issue_command(bnb_pkg::CMD_CLEAR, f, 1'($urandom));
               sent++;
            end else if (r < 8) begin
               issue_command(bnb_pkg::CMD_NOP, f, 1'($urandom));
            end else if (r < 55) begin
               // A biased episode trains one class only; the other gets no training in that episode.
               issue_command(bnb_pkg::CMD_TRAIN, f, (bias == 0) ? 1'($urandom) : (bias == 2));
               sent++;
            end else begin
               issue_command(bnb_pkg::CMD_QUERY, f, 1'($urandom));
               sent++;
            end
         end
         if ($urandom_range(0, 2) == 0) wait_for_answers();
      end
      wait_for_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results: %0d training transactions, %0d dropped at a full count,",
               tracker.results_seen, tracker.trains, tracker.dropped);
      $display("%0d queries, %0d on an empty class, and %0d clears and no-operations.",
               tracker.queries, tracker.empty_queries, tracker.others);
      if (tracker.mismatches == 0) begin
         $display("PASS binary_naive_bayes_classifier_core");
      end else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("FAIL binary_naive_bayes_classifier_core");
      end
      $finish;
   end
endmodule
